/* hdl/clf_pkg.sv */
// shared types, widths and constants for the cpu load factor averager
package clf_pkg;

    localparam int CPU_SLOTS = 16;

    localparam int CPU_W     = 5;
    localparam int Q_W       = 10;
    localparam int JOB_W     = 16;
    localparam int FRAC_BITS = 16;
    localparam int AVG_W     = 21;
    localparam int ALPHA_W   = 17;
    localparam int NUM_AVG   = 3;
    localparam int IDX_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 96;

    localparam int DIV_W       = CPU_W + FRAC_BITS;
    localparam int DIVISOR_W   = JOB_W + 1;
    localparam int DIV_CNT_W   = $clog2(DIV_W + 1);

    localparam logic [CPU_W-1:0] CPU_CAP =
        (CPU_SLOTS < 31) ? CPU_W'(CPU_SLOTS) : CPU_W'(31);
    localparam logic [JOB_W-1:0] JOB_MAX = {JOB_W{1'b1}};
    localparam logic [AVG_W-1:0] AVG_MAX = {AVG_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SHORT       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_MINUTE      = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_FIVE_MINUTE = CFG_IDX_W'(2);

    localparam logic [ALPHA_W-1:0] ALPHA_SHORT_RST       = ALPHA_W'(13107);
    localparam logic [ALPHA_W-1:0] ALPHA_MINUTE_RST      = ALPHA_W'(1092);
    localparam logic [ALPHA_W-1:0] ALPHA_FIVE_MINUTE_RST = ALPHA_W'(218);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_DIV,
        ST_MUL,
        ST_UPD,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* hdl/cpu_load_factor_averager.sv */
// top level: slot accumulation, sequencer and result register
//
// input stream: one transfer per processor slot, s_tlast closes the sample.
// s_tdata carries cpu_running, cpu_queue_count and global_queue_count.
// a transfer without s_tlast is absorbed and gives no result.
// the closing transfer starts the computation and drops s_tready until it
// is done: the instant factor is set directly (more processors than jobs)
// or computed in the bit-serial divider, then the three averages pass one
// after another through one multiplier, each through multiply and update.
// m_tdata holds the result in a register until m_tready takes it; while it
// waits the block keeps absorbing slot transfers, and a following closing
// transfer finishes its computation and then waits for the register.
// reset clears the sums, the averages and the seeded flag and loads the
// default weights. weights are written through cfg_we, cfg_index, cfg_data;
// the user must write them only while idle; the block itself does not enforce it.
module cpu_load_factor_averager (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // cpu_running, cpu_queue_count, global_queue_count, zero pad
    input  logic [clf_pkg::S_TDATA_W-1:0]         s_tdata,
    input  logic                                  s_tlast,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // instant_factor, avg_short, avg_minute, avg_five_minute, running_cpus, zero pad
    output logic [clf_pkg::M_TDATA_W-1:0]         m_tdata,
    input  logic                                  cfg_we,
    input  logic [clf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [clf_pkg::ALPHA_W-1:0]           cfg_data
);

    localparam int PAD_W = clf_pkg::M_TDATA_W - clf_pkg::CPU_W
                           - (clf_pkg::NUM_AVG + 1) * clf_pkg::AVG_W;

    clf_pkg::state_t state_reg, state_next;

    logic [clf_pkg::CPU_W-1:0]   cpu_sum_reg, cpu_sum_next;
    logic [clf_pkg::JOB_W-1:0]   job_sum_reg, job_sum_next;
    logic [clf_pkg::CPU_W-1:0]   cpus_reg, cpus_next;
    logic [clf_pkg::JOB_W-1:0]   jobs_reg, jobs_next;
    logic [clf_pkg::AVG_W-1:0]   inst_reg, inst_next;
    logic                        seeded_reg, seeded_next;
    logic [clf_pkg::AVG_W-1:0]   avg_reg [clf_pkg::NUM_AVG];
    logic [clf_pkg::AVG_W-1:0]   avg_next [clf_pkg::NUM_AVG];
    logic [clf_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [clf_pkg::ALPHA_W-1:0] alpha_reg [clf_pkg::NUM_AVG];
    logic [clf_pkg::ALPHA_W-1:0] alpha_next [clf_pkg::NUM_AVG];
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [clf_pkg::M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                        in_running;
    logic [clf_pkg::Q_W-1:0]     in_local;
    logic [clf_pkg::Q_W-1:0]     in_global;
    logic [clf_pkg::CPU_W-1:0]   cpu_acc;
    logic [clf_pkg::JOB_W-1:0]   job_run;
    logic [clf_pkg::JOB_W-1:0]   job_all;

    logic                        div_start;
    logic [clf_pkg::DIV_W-1:0]   div_dividend;
    logic [clf_pkg::DIVISOR_W-1:0] div_divisor;
    logic [clf_pkg::DIV_W-1:0]   div_quotient;
    clf_pkg::div_status_t        div_status;

    logic                        mul_en;
    logic [clf_pkg::AVG_W-1:0]   avg_new;

    function automatic logic [clf_pkg::JOB_W-1:0] sat_add(
        input logic [clf_pkg::JOB_W-1:0] a,
        input logic [clf_pkg::Q_W-1:0]   b
    );
        logic [clf_pkg::JOB_W:0] s;
        s = {1'b0, a} + (clf_pkg::JOB_W + 1)'(b);
        return s[clf_pkg::JOB_W] ? clf_pkg::JOB_MAX : s[clf_pkg::JOB_W-1:0];
    endfunction

    assign div_dividend = {cpus_reg, {clf_pkg::FRAC_BITS{1'b0}}};
    assign div_divisor  = {1'b0, jobs_reg} + clf_pkg::DIVISOR_W'(1);

    clf_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .status   (div_status)
    );

    clf_ema u_ema (
        .aclk    (aclk),
        .mul_en  (mul_en),
        .inst    (inst_reg),
        .avg     (avg_reg[idx_reg]),
        .alpha   (alpha_reg[idx_reg]),
        .avg_new (avg_new)
    );

    always_comb begin
        in_running = s_tdata[0];
        in_local   = s_tdata[clf_pkg::Q_W:1];
        in_global  = s_tdata[2*clf_pkg::Q_W:clf_pkg::Q_W+1];
        cpu_acc    = (in_running && (cpu_sum_reg < clf_pkg::CPU_CAP))
                     ? cpu_sum_reg + clf_pkg::CPU_W'(1) : cpu_sum_reg;
        job_run    = sat_add(job_sum_reg, in_running ? in_local : '0);
        job_all    = sat_add(job_run, in_global);
    end

    always_comb begin
        state_next    = state_reg;
        cpu_sum_next  = cpu_sum_reg;
        job_sum_next  = job_sum_reg;
        cpus_next     = cpus_reg;
        jobs_next     = jobs_reg;
        inst_next     = inst_reg;
        seeded_next   = seeded_reg;
        avg_next      = avg_reg;
        idx_next      = idx_reg;
        alpha_next    = alpha_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        s_tready      = 1'b0;
        div_start     = 1'b0;
        mul_en        = 1'b0;

        if (cfg_we) begin
            unique case (cfg_index)
                clf_pkg::CFG_ALPHA_SHORT:       alpha_next[0] = cfg_data;
                clf_pkg::CFG_ALPHA_MINUTE:      alpha_next[1] = cfg_data;
                clf_pkg::CFG_ALPHA_FIVE_MINUTE: alpha_next[2] = cfg_data;
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            clf_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tlast) begin
                        cpus_next    = cpu_acc;
                        jobs_next    = job_all;
                        cpu_sum_next = '0;
                        job_sum_next = '0;
                        state_next   = clf_pkg::ST_SETUP;
                    end else begin
                        cpu_sum_next = cpu_acc;
                        job_sum_next = job_run;
                    end
                end
            end
            clf_pkg::ST_SETUP: begin
                if (!seeded_reg) begin
                    for (int i = 0; i < clf_pkg::NUM_AVG; i++) begin
                        avg_next[i] = {cpus_reg, {clf_pkg::FRAC_BITS{1'b0}}};
                    end
                    seeded_next = 1'b1;
                end
                idx_next = '0;
                if ({{(clf_pkg::JOB_W-clf_pkg::CPU_W){1'b0}}, cpus_reg} > jobs_reg) begin
                    inst_next  = {cpus_reg - jobs_reg[clf_pkg::CPU_W-1:0],
                                  {clf_pkg::FRAC_BITS{1'b0}}};
                    state_next = clf_pkg::ST_MUL;
                end else begin
                    div_start  = 1'b1;
                    state_next = clf_pkg::ST_DIV;
                end
            end
            clf_pkg::ST_DIV: begin
                if (div_status.done) begin
                    inst_next  = div_quotient;
                    state_next = clf_pkg::ST_MUL;
                end
            end
            clf_pkg::ST_MUL: begin
                mul_en     = 1'b1;
                state_next = clf_pkg::ST_UPD;
            end
            clf_pkg::ST_UPD: begin
                avg_next[idx_reg] = avg_new;
                if (idx_reg == clf_pkg::IDX_W'(clf_pkg::NUM_AVG - 1)) begin
                    state_next = clf_pkg::ST_OUT;
                end else begin
                    idx_next   = idx_reg + clf_pkg::IDX_W'(1);
                    state_next = clf_pkg::ST_MUL;
                end
            end
            clf_pkg::ST_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{PAD_W{1'b0}}, cpus_reg,
                                     avg_reg[2], avg_reg[1], avg_reg[0], inst_reg};
                    state_next    = clf_pkg::ST_IDLE;
                end
            end
            default: state_next = clf_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= clf_pkg::ST_IDLE;
            cpu_sum_reg  <= '0;
            job_sum_reg  <= '0;
            seeded_reg   <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < clf_pkg::NUM_AVG; i++) begin
                avg_reg[i] <= '0;
            end
            alpha_reg[0] <= clf_pkg::ALPHA_SHORT_RST;
            alpha_reg[1] <= clf_pkg::ALPHA_MINUTE_RST;
            alpha_reg[2] <= clf_pkg::ALPHA_FIVE_MINUTE_RST;
        end else begin
            state_reg    <= state_next;
            cpu_sum_reg  <= cpu_sum_next;
            job_sum_reg  <= job_sum_next;
            seeded_reg   <= seeded_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
            avg_reg      <= avg_next;
            alpha_reg    <= alpha_next;
        end
    end

    always_ff @(posedge aclk) begin
        cpus_reg    <= cpus_next;
        jobs_reg    <= jobs_next;
        inst_reg    <= inst_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_close_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tlast) |=> !s_tready)
        else $error("input still ready after closing transfer");

    a_div_active: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == clf_pkg::ST_DIV) |-> (div_status.busy || div_status.done))
        else $error("waiting on an idle divider");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == clf_pkg::ST_OUT))
        else $error("result raised outside the output state");

    a_cpu_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[88:84] <= clf_pkg::CPU_CAP))
        else $error("running count above its cap");

endmodule

/* hdl/clf_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
module clf_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [clf_pkg::DIV_W-1:0]           dividend,
    input  logic [clf_pkg::DIVISOR_W-1:0]       divisor,
    output logic [clf_pkg::DIV_W-1:0]           quotient,
    output clf_pkg::div_status_t                status
);

    logic [clf_pkg::DIVISOR_W-1:0] rem_reg, rem_next;
    logic [clf_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [clf_pkg::DIVISOR_W-1:0] divisor_reg, divisor_next;
    logic [clf_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;

    logic [clf_pkg::DIVISOR_W:0]   rem_sh;
    logic [clf_pkg::DIVISOR_W:0]   diff;
    logic                          ge;

    always_comb begin
        rem_sh       = {rem_reg, quo_reg[clf_pkg::DIV_W-1]};
        diff         = rem_sh - {1'b0, divisor_reg};
        ge           = !diff[clf_pkg::DIVISOR_W];
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start) begin
            rem_next     = '0;
            quo_next     = dividend;
            divisor_next = divisor;
            cnt_next     = clf_pkg::DIV_CNT_W'(clf_pkg::DIV_W);
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            rem_next = ge ? diff[clf_pkg::DIVISOR_W-1:0] : rem_sh[clf_pkg::DIVISOR_W-1:0];
            quo_next = {quo_reg[clf_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg - clf_pkg::DIV_CNT_W'(1);
            if (cnt_reg == clf_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        divisor_reg <= divisor_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* hdl/clf_ema.sv */
// shared multiplier and clamped update for one moving average
module clf_ema (
    input  logic                          aclk,
    input  logic                          mul_en,
    input  logic [clf_pkg::AVG_W-1:0]     inst,
    input  logic [clf_pkg::AVG_W-1:0]     avg,
    input  logic [clf_pkg::ALPHA_W-1:0]   alpha,
    output logic [clf_pkg::AVG_W-1:0]     avg_new
);

    localparam int DIFF_W = clf_pkg::AVG_W + 1;
    localparam int ALS_W  = clf_pkg::ALPHA_W + 1;
    localparam int PROD_W = DIFF_W + ALS_W;
    localparam int STEP_W = PROD_W - clf_pkg::FRAC_BITS;
    localparam int SUM_W  = STEP_W + 1;

    logic signed [DIFF_W-1:0] diff;
    logic signed [ALS_W-1:0]  alpha_s;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [STEP_W-1:0] step;
    logic signed [SUM_W-1:0]  sum;

    always_comb begin
        diff      = $signed({1'b0, inst}) - $signed({1'b0, avg});
        alpha_s   = $signed({1'b0, alpha});
        prod_next = diff * alpha_s;
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_next;
        end
    end

    always_comb begin
        // arithmetic shift keeps the floor for negative steps
        step = prod_reg[PROD_W-1:clf_pkg::FRAC_BITS];
        sum  = $signed({{(SUM_W-clf_pkg::AVG_W){1'b0}}, avg}) + $signed({step[STEP_W-1], step});
        if (sum[SUM_W-1]) begin
            avg_new = '0;
        end else if (|sum[SUM_W-2:clf_pkg::AVG_W]) begin
            avg_new = clf_pkg::AVG_MAX;
        end else begin
            avg_new = sum[clf_pkg::AVG_W-1:0];
        end
    end

endmodule

/* sim/cpu_load_factor_averager_checker.sv */
// checker: follows slot and result transfers, predicts each load report and compares it
module cpu_load_factor_averager_checker
    import clf_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    // cpu_running, cpu_queue_count, global_queue_count, zero pad
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    // instant_factor, avg_short, avg_minute, avg_five_minute, running_cpus, zero pad
    input  logic [M_TDATA_W-1:0] m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ALPHA_W-1:0]   cfg_data,
    output int                   fail_count,
    output int                   expected_left
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PROD_W = AVG_W + ALPHA_W + 3;

    typedef struct packed {
        logic [CPU_W-1:0] cpus;
        logic [AVG_W-1:0] avg_five;
        logic [AVG_W-1:0] avg_minute;
        logic [AVG_W-1:0] avg_short;
        logic [AVG_W-1:0] instant;
    } load_report_t;

    logic [ALPHA_W-1:0] weight [NUM_AVG];
    logic [AVG_W-1:0]   level  [NUM_AVG];
    logic               seeded;
    logic [CPU_W-1:0]   cpu_tally;
    logic [JOB_W-1:0]   job_tally;
    load_report_t       reports [$];
    load_report_t       want;
    load_report_t       got;
    int                 fails = 0;

    function automatic logic [JOB_W-1:0] add_jobs(input logic [JOB_W-1:0] sum,
                                                  input logic [Q_W-1:0] n);
        logic [JOB_W:0] s;
        s = {1'b0, sum} + {{(JOB_W+1-Q_W){1'b0}}, n};
        return (s > {1'b0, JOB_MAX}) ? JOB_MAX : s[JOB_W-1:0];
    endfunction

    // signed step with floor shift, then clamp to the field range
    function automatic logic [AVG_W-1:0] move_level(input logic [AVG_W-1:0] avg,
                                                    input logic [AVG_W-1:0] inst,
                                                    input logic [ALPHA_W-1:0] alpha);
        logic signed [AVG_W+1:0]  diff;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] moved;
        diff  = $signed({2'b00, inst}) - $signed({2'b00, avg});
        prod  = diff * $signed({1'b0, alpha});
        moved = $signed({{(PROD_W-AVG_W){1'b0}}, avg}) + (prod >>> FRAC_BITS);
        if (moved < 0) begin
            return '0;
        end else if (moved > $signed({{(PROD_W-AVG_W){1'b0}}, AVG_MAX})) begin
            return AVG_MAX;
        end
        return moved[AVG_W-1:0];
    endfunction

    task automatic absorb_slot(input logic [S_TDATA_W-1:0] data, input logic last);
        logic [AVG_W-1:0] inst;
        logic [AVG_W-1:0] surplus;
        load_report_t     rep;
        if (data[0]) begin
            if (cpu_tally < CPU_CAP) begin
                cpu_tally = cpu_tally + 1'b1;
            end
            job_tally = add_jobs(job_tally, data[Q_W:1]);
        end
        if (last) begin
            job_tally = add_jobs(job_tally, data[2*Q_W:Q_W+1]);
            if (AVG_W'(cpu_tally) > AVG_W'(job_tally)) begin
                surplus = AVG_W'(cpu_tally) - AVG_W'(job_tally);
                inst = surplus << FRAC_BITS;
            end else begin
                inst = {cpu_tally, {FRAC_BITS{1'b0}}} / ({1'b0, job_tally} + 1'b1);
            end
            if (!seeded) begin
                for (int i = 0; i < NUM_AVG; i++) begin
                    level[i] = {cpu_tally, {FRAC_BITS{1'b0}}};
                end
                seeded = 1'b1;
            end
            for (int i = 0; i < NUM_AVG; i++) begin
                level[i] = move_level(level[i], inst, weight[i]);
            end
            rep.instant    = inst;
            rep.avg_short  = level[0];
            rep.avg_minute = level[1];
            rep.avg_five   = level[2];
            rep.cpus       = cpu_tally;
            reports.push_back(rep);
            cpu_tally = '0;
            job_tally = '0;
        end
    endtask

    task automatic check_field(input string name, input logic [AVG_W-1:0] exp_val,
                               input logic [AVG_W-1:0] act_val);
        if (exp_val !== act_val) begin
            fails++;
            $display("%0t: %s expected %0d got %0d", $time, name, exp_val, act_val);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            weight[CFG_ALPHA_SHORT]       = ALPHA_SHORT_RST;
            weight[CFG_ALPHA_MINUTE]      = ALPHA_MINUTE_RST;
            weight[CFG_ALPHA_FIVE_MINUTE] = ALPHA_FIVE_MINUTE_RST;
            for (int i = 0; i < NUM_AVG; i++) begin
                level[i] = '0;
            end
            seeded    = 1'b0;
            cpu_tally = '0;
            job_tally = '0;
            reports.delete();
        end else begin
            if (cfg_we && cfg_index < NUM_AVG) begin
                weight[cfg_index] = cfg_data;
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[$bits(load_report_t)-1:0];
                if (reports.size() == 0) begin
                    fails++;
                    $display("%0t: result transfer expected none got %h", $time, got);
                end else begin
                    want = reports.pop_front();
                    check_field("instant_factor", want.instant, got.instant);
                    check_field("avg_short", want.avg_short, got.avg_short);
                    check_field("avg_minute", want.avg_minute, got.avg_minute);
                    check_field("avg_five_minute", want.avg_five, got.avg_five);
                    check_field("running_cpus", AVG_W'(want.cpus), AVG_W'(got.cpus));
                end
            end
            if (s_tvalid && s_tready) begin
                absorb_slot(s_tdata, s_tlast);
            end
        end
        fail_count    <= fails;
        expected_left <= reports.size();
    end

endmodule

/* sim/cpu_load_factor_averager_tb.sv */
// testbench top: clock, reset, slot stimulus, weight changes and the verdict
module cpu_load_factor_averager_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import clf_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_SLOTS    = 217;
    localparam int MAX_GAP        = 18;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = CFG_IDX_W'(3);
    localparam logic [ALPHA_W-1:0]   ALPHA_ONE  = ALPHA_W'(65536);
    localparam logic [ALPHA_W-1:0]   ALPHA_TOP  = {ALPHA_W{1'b1}};

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ALPHA_W-1:0]   cfg_data;

    int fails;
    int outstanding;
    int idle_cycles = 0;
    int slots_sent  = 0;
    bit sender_burst = 1'b0;
    bit taker_burst  = 1'b0;

    cpu_load_factor_averager dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cpu_load_factor_averager_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fails),
        .expected_left (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("** cpu_load_factor_averager: FAILED **");
                $finish;
            end
        end
    end

    // valid stays high into the next slot when no gap is drawn
    task automatic send_slot(input logic running, input logic [Q_W-1:0] own_q,
                             input logic [Q_W-1:0] shared_q, input logic last);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({shared_q, own_q, running});
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        slots_sent++;
    endtask

    function automatic logic [Q_W-1:0] pick_queue(input bit light);
        int r;
        r = $urandom_range(0, 9);
        if (light) begin
            return (r < 9) ? '0 : Q_W'($urandom_range(0, 2));
        end
        case (r)
            0, 1, 2: return '0;
            3, 4, 5: return Q_W'($urandom_range(0, 3));
            6, 7, 8: return Q_W'($urandom_range(0, 1023));
            default: return Q_W'($urandom_range(1016, 1023));
        endcase
    endfunction

    task automatic send_random_sample();
        int kind;
        int n;
        bit light;
        bit overload;
        if ($urandom_range(0, 7) == 0) begin
            sender_burst = !sender_burst;
        end
        kind     = $urandom_range(0, 99);
        light    = $urandom_range(0, 1);
        overload = 1'b0;
        if (kind < 5) begin
            n = 1;
        end else if (kind < 85) begin
            n = $urandom_range(2, CPU_SLOTS);
        end else if (kind < 97) begin
            n = $urandom_range(CPU_SLOTS + 1, CPU_SLOTS + 8);
        end else begin
            n = $urandom_range(68, 76);
            overload = 1'b1;
        end
        for (int i = 0; i < n; i++) begin
            if (overload) begin
                send_slot(1'b1, Q_W'($urandom_range(1000, 1023)),
                          Q_W'($urandom_range(1000, 1023)), i == n - 1);
            end else begin
                send_slot($urandom_range(0, 3) != 0, pick_queue(light), pick_queue(light),
                          i == n - 1);
            end
        end
    endtask

    task automatic write_weight(input logic [CFG_IDX_W-1:0] idx,
                                input logic [ALPHA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    task automatic set_weights(input logic [ALPHA_W-1:0] w_short,
                               input logic [ALPHA_W-1:0] w_minute,
                               input logic [ALPHA_W-1:0] w_five);
        write_weight(CFG_ALPHA_SHORT, w_short);
        write_weight(CFG_ALPHA_MINUTE, w_minute);
        write_weight(CFG_ALPHA_FIVE_MINUTE, w_five);
        cfg_we <= 1'b0;
    endtask

    // one edge first so the count includes the last closing transfer
    task automatic drain();
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : taker
        int stall;
        m_tready = 1'b0;
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                taker_burst = !taker_burst;
            end
            stall = taker_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // first sample seeds the averages, light load
        send_slot(1'b1, '0, '0, 1'b0);
        send_slot(1'b1, '0, '0, 1'b0);
        send_slot(1'b1, '0, '0, 1'b1);
        // nothing running and no jobs
        send_slot(1'b0, '0, '0, 1'b1);
        // single slot with full queues, division path
        send_slot(1'b1, {Q_W{1'b1}}, {Q_W{1'b1}}, 1'b1);
        // alternating bit patterns, idle slot with a queue that is ignored
        send_slot(1'b1, Q_W'(10'h2AA), Q_W'(10'h155), 1'b0);
        send_slot(1'b0, {Q_W{1'b1}}, Q_W'(10'h2AA), 1'b0);
        send_slot(1'b1, Q_W'(10'h155), Q_W'(10'h2AA), 1'b0);
        send_slot(1'b1, '0, Q_W'(10'h155), 1'b1);
        // running count saturates past the slot count
        for (int i = 0; i <= CPU_SLOTS; i++) begin
            send_slot(1'b1, '0, '0, i == CPU_SLOTS);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                s_tvalid <= 1'b0;
                drain();
                case (phase)
                    1: set_weights('0, '0, '0);
                    2: set_weights(ALPHA_ONE, ALPHA_ONE, ALPHA_ONE);
                    3: set_weights(ALPHA_TOP, ALPHA_TOP, ALPHA_TOP);
                    4: begin
                        write_weight(CFG_UNUSED, ALPHA_W'($urandom()));
                        set_weights(ALPHA_W'($urandom()), ALPHA_W'($urandom()),
                                    ALPHA_W'($urandom()));
                    end
                    default: set_weights(ALPHA_ONE - 1'b1, ALPHA_W'(1),
                                         ALPHA_W'($urandom_range(0, 65536)));
                endcase
            end
            slots_sent = 0;
            while (slots_sent < PHASE_SLOTS) begin
                send_random_sample();
            end
        end
        s_tvalid <= 1'b0;
        drain();

        if (fails == 0 && outstanding == 0) begin
            $display("** cpu_load_factor_averager: PASSED **");
        end else begin
            $display("** cpu_load_factor_averager: FAILED **");
        end
        $finish;
    end

endmodule
